[hdl/cursor_array_list_assert.svh]
// Assertion macros for the cursor array list block.
// Included by the top level; uses the clk and rst_n names of the including module.
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset
`define CAL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cursor_array_list: assertion failed");

// Condition in one cycle implies a condition in the next
`define CAL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cursor_array_list: assertion failed");

`else

`define CAL_ASSERT_ALWAYS(lbl, cond)
`define CAL_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

[hdl/cal_pkg.sv]
// Shared types and codes of the cursor array list block.
// No dependencies; used by cal_cell, cal_row and cursor_array_list.
package cal_pkg;

  // Command codes carried in the command field
  typedef enum logic [3:0] {
    CMD_RD_CUR  = 4'd0,
    CMD_PREV    = 4'd1,
    CMD_NEXT    = 4'd2,
    CMD_FIRST   = 4'd3,
    CMD_LAST    = 4'd4,
    CMD_DELETE  = 4'd5,
    CMD_INS_BEF = 4'd6,
    CMD_INS_AFT = 4'd7,
    CMD_RD_IDX  = 4'd8,
    CMD_WR_IDX  = 4'd9,
    CMD_WR_CUR  = 4'd10
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_SHIFT_DN = 2'd1,  // cells at or above pivot take the upper neighbor
    CELL_SHIFT_UP = 2'd2,  // cells above pivot take the lower neighbor, pivot loads
    CELL_WRITE    = 2'd3   // pivot cell loads the write word
  } cell_op_t;

  // Input transaction
  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] value;
    logic [3:0]  position;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic        moved;
    logic [1:0]  status;
    logic [4:0]  length;
    logic [3:0]  cursor_pos;
  } out_item_t;

endpackage

[hdl/cal_cell.sv]
// One storage cell of the list row: holds one element word.
// Depends on cal_pkg for the cell operation codes.
module cal_cell import cal_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [IDX_W-1:0]      pivot,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Next word from the broadcast operation and this cell's place
  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_HOLD: data_nxt = data_r;
      CELL_SHIFT_DN: begin
        if (MY_IDX >= pivot) data_nxt = upper_data;
      end
      CELL_SHIFT_UP: begin
        if (MY_IDX > pivot) data_nxt = lower_data;
        else if (MY_IDX == pivot) data_nxt = wdata;
      end
      CELL_WRITE: begin
        if (MY_IDX == pivot) data_nxt = wdata;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Element word, no reset (contents undefined until written)
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[hdl/cal_row.sv]
// Row of list cells chained to their neighbors, plus one read port.
// Depends on cal_pkg and cal_cell.
module cal_row import cal_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [IDX_W-1:0]      pivot,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  // Each cell sees its lower and upper neighbor; ends loop back on themselves
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    if (g == 0) begin : g_lo_end
      assign lower = cell_data[g];
    end else begin : g_lo
      assign lower = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper = cell_data[g];
    end else begin : g_hi
      assign upper = cell_data[g+1];
    end

    cal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .pivot      (pivot),
      .wdata      (wdata),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g])
    );
  end

  // Single read port: cursor or indexed read
  assign rdata = cell_data[raddr];

endmodule

[hdl/cursor_array_list.sv]
// cursor_array_list: list of up to CAPACITY words held in a chained row of cells.
// Each accepted command has its result registered in the output register.
// Throughput: one command per cycle unless stalled; every cell shifts at once.
// Reset clears length, cursor and the output valid; cell contents stay undefined
// until written and need no clearing pass.
`include "cursor_array_list_assert.svh"

module cursor_array_list import cal_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [31:0]      CAP_U   = 32'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

  // List state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Command decode
  logic                  in_acc;
  logic                  empty;
  logic                  full;
  logic                  needs_items;
  logic [31:0]           pos32;
  logic [IDX_W-1:0]      pos_idx;
  logic                  bad_idx;
  logic [63:0]           val64;
  logic [DATA_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [63:0]           rd64;
  logic [31:0]           rd_word;
  logic                  moved;
  status_t               status;
  cell_op_t              op;
  cell_op_t              row_op;
  logic [IDX_W-1:0]      pivot;
  logic [31:0]           cnt32;
  logic [31:0]           cur32;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign empty = (count_r == '0);
  assign full  = (count_r == CAP_CNT);
  assign needs_items = (in_data.command <= CMD_DELETE) ||
                       (in_data.command == CMD_RD_IDX) ||
                       (in_data.command == CMD_WR_IDX) ||
                       (in_data.command == CMD_WR_CUR);

  assign pos32   = 32'(in_data.position);
  assign pos_idx = pos32[IDX_W-1:0];
  assign bad_idx = (pos32 >= 32'(count_r)) || (pos32 >= CAP_U);

  assign val64 = 64'(in_data.value);
  assign wdata = val64[DATA_WIDTH-1:0];

  // Shared read port address
  assign raddr = (in_data.command == CMD_RD_IDX) ? pos_idx : cursor_r;

  cal_row #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_row (
    .clk   (clk),
    .op    (row_op),
    .pivot (pivot),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd64 = 64'(rdata);

  // Command execution against current length and cursor
  always_comb begin
    rd_word    = '0;
    moved      = 1'b0;
    status     = ST_OK;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    op         = CELL_HOLD;
    pivot      = cursor_r;
    if (needs_items && empty) begin
      status = ST_EMPTY;
    end else begin
      unique case (in_data.command)
        CMD_RD_CUR: rd_word = rd64[31:0];
        CMD_PREV: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - ONE_IDX;
            moved      = 1'b1;
          end
        end
        CMD_NEXT: begin
          if (CNT_W'(cursor_r) + ONE_CNT < count_r) begin
            cursor_nxt = cursor_r + ONE_IDX;
            moved      = 1'b1;
          end
        end
        CMD_FIRST: cursor_nxt = '0;
        CMD_LAST:  cursor_nxt = IDX_W'(count_r - ONE_CNT);
        CMD_DELETE: begin
          op        = CELL_SHIFT_DN;
          count_nxt = count_r - ONE_CNT;
          // deleting the tail element steps the cursor back
          if (CNT_W'(cursor_r) == count_r - ONE_CNT && cursor_r != '0) begin
            cursor_nxt = cursor_r - ONE_IDX;
          end
        end
        CMD_INS_BEF, CMD_INS_AFT: begin
          if (empty) begin
            op         = CELL_WRITE;
            pivot      = '0;
            cursor_nxt = '0;
            count_nxt  = ONE_CNT;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            op        = CELL_SHIFT_UP;
            count_nxt = count_r + ONE_CNT;
            if (in_data.command == CMD_INS_BEF) begin
              pivot      = cursor_r;
              cursor_nxt = cursor_r + ONE_IDX;
            end else begin
              pivot = cursor_r + ONE_IDX;
            end
          end
        end
        CMD_RD_IDX: begin
          if (bad_idx) status = ST_BADIDX;
          else rd_word = rd64[31:0];
        end
        CMD_WR_IDX: begin
          if (bad_idx) begin
            status = ST_BADIDX;
          end else begin
            op    = CELL_WRITE;
            pivot = pos_idx;
          end
        end
        CMD_WR_CUR: op = CELL_WRITE;
        default: ;
      endcase
    end
  end

  // Cells change only on an accepted transaction
  assign row_op = in_acc ? op : CELL_HOLD;

  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
      end
    end
  end

  assign cnt32 = 32'(count_nxt);
  assign cur32 = 32'(cursor_nxt);

  // Result register, loaded per accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.read_data  <= rd_word;
      out_data_r.moved      <= moved;
      out_data_r.status     <= status;
      out_data_r.length     <= cnt32[4:0];
      out_data_r.cursor_pos <= cur32[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `CAL_ASSERT_ALWAYS(a_count_bound, count_r <= CAP_CNT)
  `CAL_ASSERT_ALWAYS(a_cursor_in_list, (cursor_r == '0) || (CNT_W'(cursor_r) < count_r))
  `CAL_ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_r)
  `CAL_ASSERT_NEXT(a_state_only_on_accept, !in_acc, $stable(count_r) && $stable(cursor_r))

endmodule
